// ===== rtl/core/mpq_pkg.sv =====
`default_nettype none

package mpq_pkg;

	localparam int OP_W     = 2;
	localparam int LEVEL_W  = 5;
	localparam int TASK_W   = 8;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_PEEK   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_PEEK   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_REMOVE = 2'd3;

	typedef struct packed {
		logic capture;
		logic exec;
		logic emit;
	} mpq_cmd_t;

	typedef struct packed {
		logic out_free;
	} mpq_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/mpq_ram.sv =====
`default_nettype none

module mpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mpq_ctrl.sv =====
`default_nettype none

module mpq_ctrl
	import mpq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     valid,
	output logic          ready,
	input  wire mpq_sts_t sts,
	output mpq_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.emit    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mpq_datapath.sv =====
`default_nettype none

module mpq_datapath
	import mpq_pkg::*;
#(
	parameter int LEVELS          = 32,
	parameter int PER_LEVEL_DEPTH = 16,
	parameter int ID_BITS         = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mpq_cmd_t            cmd,
	output mpq_sts_t                 sts,
	input  wire logic [OP_W-1:0]     operation,
	input  wire logic [LEVEL_W-1:0]  level,
	input  wire logic [TASK_W-1:0]   task_id,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [STATUS_W-1:0] status,
	output logic      [TASK_W-1:0]   task_out,
	output logic      [LEVEL_W-1:0]  level_out
);

	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int HEAD_W = $clog2(PER_LEVEL_DEPTH);
	localparam int CNT_W  = $clog2(PER_LEVEL_DEPTH + 1);
	localparam int ADDR_W = $clog2(LEVELS * PER_LEVEL_DEPTH);

	logic [OP_W-1:0]    op_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [ID_BITS-1:0] id_q;

	logic [LEVELS-1:0]  mask_q;
	logic [HEAD_W-1:0]  head_q [LEVELS];
	logic [CNT_W-1:0]   cnt_q  [LEVELS];

	logic [STATUS_W-1:0] res_status_q;
	logic [LEVEL_W-1:0]  res_level_q;
	logic                res_fetch_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [TASK_W-1:0]   task_q;
	logic [LEVEL_W-1:0]  level_q;

	logic               any;
	logic [LVL_W-1:0]   top_idx;
	logic [LVL_W-1:0]   sel_idx;
	logic               lvl_ok;
	logic [HEAD_W-1:0]  head_sel;
	logic [CNT_W-1:0]   cnt_sel;
	logic [HEAD_W:0]    pos_sum;
	logic [HEAD_W-1:0]  tail_pos;
	logic [HEAD_W-1:0]  head_next;
	logic               full;
	logic               is_add;
	logic               is_pop;
	logic               add_ok;
	logic               pop_ok;
	logic [ADDR_W-1:0]  ram_addr;
	logic [STATUS_W-1:0] res_status_d;
	logic [ID_BITS-1:0] rd_data;

	assign any = |mask_q;

	always_comb begin
		top_idx = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (mask_q[l]) begin
				top_idx = LVL_W'(l);
			end
		end
	end

	always_comb begin
		is_add   = (op_q == OP_ADD);
		is_pop   = (op_q == OP_PEEK) || (op_q == OP_REMOVE);
		lvl_ok   = (int'(lvl_q) < LEVELS);
		sel_idx  = is_add ? lvl_q[LVL_W-1:0] : top_idx;
		head_sel = head_q[sel_idx];
		cnt_sel  = cnt_q[sel_idx];
		full     = (cnt_sel == CNT_W'(PER_LEVEL_DEPTH));
		pos_sum  = (HEAD_W+1)'(head_sel) + (HEAD_W+1)'(cnt_sel);
		if (pos_sum >= (HEAD_W+1)'(PER_LEVEL_DEPTH)) begin
			pos_sum = pos_sum - (HEAD_W+1)'(PER_LEVEL_DEPTH);
		end
		tail_pos  = pos_sum[HEAD_W-1:0];
		head_next = (head_sel == HEAD_W'(PER_LEVEL_DEPTH - 1)) ? '0 : head_sel + 1'b1;
		add_ok    = is_add && lvl_ok && !full;
		pop_ok    = is_pop && any;
		ram_addr  = ADDR_W'(sel_idx) * ADDR_W'(PER_LEVEL_DEPTH)
			+ ADDR_W'(is_add ? tail_pos : head_sel);
		priority if (is_add) begin
			res_status_d = add_ok ? ST_OK : ST_FULL;
		end else if (op_q == OP_PEEK) begin
			res_status_d = any ? ST_OK : ST_NO_PEEK;
		end else if (op_q == OP_REMOVE) begin
			res_status_d = any ? ST_OK : ST_NO_REMOVE;
		end else begin
			res_status_d = ST_OK;
		end
	end

	mpq_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (LEVELS * PER_LEVEL_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.exec && add_ok),
		.waddr (ram_addr),
		.wdata (id_q),
		.re    (cmd.exec && pop_ok),
		.raddr (ram_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			lvl_q <= level;
			id_q  <= ID_BITS'(task_id);
		end
		if (cmd.exec) begin
			res_status_q <= res_status_d;
			res_level_q  <= pop_ok ? LEVEL_W'(top_idx) : '0;
			res_fetch_q  <= pop_ok;
		end
		if (cmd.emit) begin
			status_q <= res_status_q;
			level_q  <= res_level_q;
			task_q   <= res_fetch_q ? TASK_W'(rd_data) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else if (cmd.exec) begin
			if (add_ok) begin
				cnt_q[sel_idx]  <= cnt_sel + 1'b1;
				mask_q[sel_idx] <= 1'b1;
			end else if (pop_ok && (op_q == OP_REMOVE)) begin
				head_q[sel_idx] <= head_next;
				cnt_q[sel_idx]  <= cnt_sel - 1'b1;
				if (cnt_sel == CNT_W'(1)) begin
					mask_q[sel_idx] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign task_out     = task_q;
	assign level_out    = level_q;

endmodule

`default_nettype wire

// ===== rtl/core/multilevel_priority_ready_queue_top.sv =====
// Multilevel priority ready queue: one FIFO ring per level, a bitmap of busy levels.
// Input channel (valid/ready): operation, level, task_id. Add appends task_id to the
// ring of the given level, peek reports the head of the highest busy level, remove
// pops it. Output channel (out_valid/out_ready): status, task_out, level_out; exactly
// one word comes back for each request, in request order.
// Steps: capture, execute with ring memory access, load of the output register; the
// load waits while the output register still holds a word that is not yet taken.
// The controller serves one request at a time and takes no new one before the last
// one's word is loaded; the ring memory gives one access per request with a registered read.
// Ready drops while a request is at work. A stalled output word sits in the output
// register; the next request is taken meanwhile and waits for the register to free.
// Reset empties every ring: bitmap, heads and counts clear at once; ring contents
// need no clearing, since only written entries are ever read.
`default_nettype none

module multilevel_priority_ready_queue_top
	import mpq_pkg::*;
#(
	parameter int LEVELS          = 32,
	parameter int PER_LEVEL_DEPTH = 16,
	parameter int ID_BITS         = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid,
	output logic                     ready,
	input  wire logic [OP_W-1:0]     operation,
	input  wire logic [LEVEL_W-1:0]  level,
	input  wire logic [TASK_W-1:0]   task_id,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [STATUS_W-1:0] status,
	output logic      [TASK_W-1:0]   task_out,
	output logic      [LEVEL_W-1:0]  level_out
);

	mpq_cmd_t cmd;
	mpq_sts_t sts;

	mpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid),
		.ready  (ready),
		.sts    (sts),
		.cmd    (cmd)
	);

	mpq_datapath #(
		.LEVELS          (LEVELS),
		.PER_LEVEL_DEPTH (PER_LEVEL_DEPTH),
		.ID_BITS         (ID_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.operation (operation),
		.level     (level),
		.task_id   (task_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.task_out  (task_out),
		.level_out (level_out)
	);

endmodule

`default_nettype wire

// ===== tb/multilevel_priority_ready_queue_top_tb.sv =====
`default_nettype none

module multilevel_priority_ready_queue_top_tb;
	import mpq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_LEVELS = 32;
	localparam int RING_DEPTH   = 16;
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;
	localparam int RANDOM_WORDS = 1900;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TASK_W-1:0]   handle;
		logic [LEVEL_W-1:0]  served;
	} queue_word_t;

	class ready_queue_mirror;
		bit [QUEUE_LEVELS-1:0] busy_levels;
		bit [TASK_W-1:0]       ring [QUEUE_LEVELS][RING_DEPTH];
		int                    head [QUEUE_LEVELS];
		int                    fill [QUEUE_LEVELS];
		queue_word_t           pending_words[$];
		int                    failures;

		function int outstanding();
			return pending_words.size();
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [LEVEL_W-1:0] lvl,
			logic [TASK_W-1:0] id);
			queue_word_t w;
			int top;
			w = '0;
			top = 0;
			if (op == OP_ADD) begin
				if (int'(lvl) >= QUEUE_LEVELS || fill[lvl] >= RING_DEPTH) begin
					w.status = ST_FULL;
				end else begin
					ring[lvl][(head[lvl] + fill[lvl]) % RING_DEPTH] = id;
					fill[lvl]++;
					busy_levels[lvl] = 1'b1;
				end
			end else if (op == OP_PEEK || op == OP_REMOVE) begin
				if (busy_levels == '0) begin
					w.status = (op == OP_PEEK) ? ST_NO_PEEK : ST_NO_REMOVE;
				end else begin
					for (int l = QUEUE_LEVELS - 1; l >= 0; l--) begin
						if (busy_levels[l]) begin
							top = l;
							break;
						end
					end
					w.handle = ring[top][head[top]];
					w.served = LEVEL_W'(top);
					if (op == OP_REMOVE) begin
						head[top] = (head[top] + 1) % RING_DEPTH;
						fill[top]--;
						if (fill[top] == 0)
							busy_levels[top] = 1'b0;
					end
				end
			end
			pending_words.push_back(w);
		endfunction

		function void flag(string what, queue_word_t want, queue_word_t got);
			failures++;
			if (failures <= 10)
				$display("%0t: %s: expected st=%0d id=%0h lvl=%0d, got st=%0d id=%0h lvl=%0d",
					$realtime, what, want.status, want.handle, want.served,
					got.status, got.handle, got.served);
		endfunction

		function void check_word(queue_word_t got);
			queue_word_t want;
			if (pending_words.size() == 0) begin
				flag("unexpected word", '0, got);
				return;
			end
			want = pending_words.pop_front();
			if (want.status !== got.status)
				flag("status", want, got);
			else if (want.handle !== got.handle)
				flag("task_out", want, got);
			else if (want.served !== got.served)
				flag("level_out", want, got);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [LEVEL_W-1:0]  level;
	logic [TASK_W-1:0]   task_id;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [TASK_W-1:0]   task_out;
	logic [LEVEL_W-1:0]  level_out;

	ready_queue_mirror mirror = new;
	bit calm;
	bit start_hold;

	multilevel_priority_ready_queue_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.ready     (ready),
		.operation (operation),
		.level     (level),
		.task_id   (task_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.task_out  (task_out),
		.level_out (level_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			mirror.check_word('{status, task_out, level_out});
	end

	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (start_hold) begin
				start_hold = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(0, 99) >= 8;
			end
		end
	end

	task automatic send_request(input logic [OP_W-1:0] op, input logic [LEVEL_W-1:0] lvl,
		input logic [TASK_W-1:0] id);
		while (!calm && $urandom_range(0, 99) < 8) begin
			valid <= 1'b0;
			@(negedge clk);
		end
		valid <= 1'b1;
		operation <= op;
		level <= lvl;
		task_id <= id;
		do @(posedge clk); while (!ready);
		mirror.note_request(op, lvl, id);
		@(negedge clk);
	endtask

	initial begin
		int counted;
		int add_pct;
		int base;
		int r;
		bit narrow;
		logic [OP_W-1:0] op;
		logic [LEVEL_W-1:0] lvl;

		arst_n = 1'b0;
		valid = 1'b0;
		operation = OP_ADD;
		level = '0;
		task_id = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(OP_PEEK, 5'd0, 8'h00);
		send_request(OP_REMOVE, 5'd31, 8'hFF);
		send_request(OP_NONE, 5'd7, 8'h5A);
		send_request(OP_ADD, 5'd31, 8'hFF);
		send_request(OP_ADD, 5'd0, 8'h00);
		send_request(OP_PEEK, 5'd0, 8'h00);
		send_request(OP_REMOVE, 5'd0, 8'h00);
		send_request(OP_REMOVE, 5'd0, 8'h00);
		for (int k = 0; k < RING_DEPTH; k++)
			send_request(OP_ADD, 5'd5, TASK_W'(k * 17) ^ ((k % 2) ? 8'hAA : 8'h55));
		send_request(OP_ADD, 5'd5, 8'hC3);
		send_request(OP_PEEK, 5'd0, 8'h3C);

		counted = 0;
		add_pct = 50;
		base = 0;
		narrow = 1'b0;
		while (counted < RANDOM_WORDS) begin
			if (counted % 50 == 0) begin
				r = $urandom_range(0, 2);
				add_pct = (r == 0) ? 30 : (r == 1) ? 50 : 75;
				narrow = $urandom_range(0, 1);
				base = $urandom_range(0, QUEUE_LEVELS - 4);
			end
			calm = counted >= 500 && counted < 800;
			if (counted == 1200)
				start_hold = 1'b1;
			r = $urandom_range(0, 99);
			if (r < add_pct)
				op = OP_ADD;
			else if (r < add_pct + (95 - add_pct) / 3)
				op = OP_PEEK;
			else if (r < 95)
				op = OP_REMOVE;
			else
				op = OP_NONE;
			lvl = narrow ? LEVEL_W'(base + $urandom_range(0, 3))
				: LEVEL_W'($urandom_range(0, QUEUE_LEVELS - 1));
			send_request(op, lvl, TASK_W'($urandom_range(0, 255)));
			if (op != OP_NONE)
				counted++;
		end
		calm = 1'b0;
		valid <= 1'b0;

		while (mirror.outstanding() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mirror.failures == 0 && mirror.outstanding() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

// ===== multilevel_priority_ready_queue_top.f =====
rtl/core/mpq_pkg.sv
rtl/core/mpq_ram.sv
rtl/core/mpq_ctrl.sv
rtl/core/mpq_datapath.sv
rtl/core/multilevel_priority_ready_queue_top.sv
tb/multilevel_priority_ready_queue_top_tb.sv
